// ===== sv/ppr_pkg.sv =====
// Shared types and constants of the propeller pulse rate meter.
package ppr_pkg;

    localparam int FUNC_W      = 2;
    localparam int STAMP_W     = 24;
    localparam int CAL_W       = 16;
    localparam int MIN_W       = 24;
    localparam int SPEED_W     = 24;
    localparam int TOTAL_W     = 16;
    localparam int SCALE_SHIFT = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_CNT_W   = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SPEED_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'd1;

    localparam logic [CAL_W-1:0]   CAL_RESET = 16'd45613;
    localparam logic [MIN_W-1:0]   MIN_RESET = 24'd32768;
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_PULSE   = 2'd0,
        FN_READ    = 2'd1,
        FN_RESTART = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic pulse;
        logic restart;
        logic capture;
        logic mul;
        logic check;
        logic step;
        logic load_out;
    } ppr_cmd_t;

    typedef struct packed {
        logic out_free;
    } ppr_stat_t;

endpackage

// ===== sv/ppr_ifs.sv =====
// Request and result channel interfaces of the propeller pulse rate meter.
interface ppr_in_if;
    logic                            valid;
    logic                            ready;
    logic [ppr_pkg::FUNC_W-1:0]      func;
    logic [ppr_pkg::STAMP_W-1:0]     now_time;

    modport source (output valid, output func, output now_time, input ready);
    modport sink   (input valid, input func, input now_time, output ready);
endinterface

interface ppr_out_if;
    logic                            valid;
    logic                            ready;
    logic [ppr_pkg::SPEED_W-1:0]     speed_q8;
    logic                            valid_res;
    logic [ppr_pkg::TOTAL_W-1:0]     pulse_total;

    modport source (output valid, output speed_q8, output valid_res, output pulse_total,
                    input ready);
    modport sink   (input valid, input speed_q8, input valid_res, input pulse_total,
                    output ready);
endinterface

// ===== sv/ppr_ctrl.sv =====
// Sequencing state machine of the propeller pulse rate meter.
module ppr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ppr_pkg::FUNC_W-1:0]  in_func,
    output logic                        in_ready,
    input  ppr_pkg::ppr_stat_t          stat,
    output ppr_pkg::ppr_cmd_t           cmd
);

    ppr_pkg::state_t                   state_reg;
    ppr_pkg::state_t                   state_next;
    logic [ppr_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [ppr_pkg::DIV_CNT_W-1:0]     cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ppr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_func)
                        ppr_pkg::FN_PULSE:   cmd.pulse = 1'b1;
                        ppr_pkg::FN_RESTART: cmd.restart = 1'b1;
                        ppr_pkg::FN_READ:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ppr_pkg::ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            ppr_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ppr_pkg::ST_CHECK;
            end
            ppr_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                cnt_next   = '0;
                state_next = ppr_pkg::ST_DIV;
            end
            ppr_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ppr_pkg::DIV_LAST)
                begin
                    state_next = ppr_pkg::ST_DONE;
                end
            end
            ppr_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ppr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ppr_dp.sv =====
// Datapath of the propeller pulse rate meter: counter, stamp, multiplier, divider.
module ppr_dp #(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ppr_pkg::ppr_cmd_t                cmd,
    output ppr_pkg::ppr_stat_t               stat,
    input  logic [ppr_pkg::STAMP_W-1:0]      now_time,
    input  logic                             wr_en,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [ppr_pkg::SPEED_W-1:0]      speed_q8,
    output logic                             valid_res,
    output logic [ppr_pkg::TOTAL_W-1:0]      pulse_total
);

    localparam int MUL_W = COUNT_BITS + ppr_pkg::CAL_W;
    localparam int NUM_W = MUL_W + ppr_pkg::SCALE_SHIFT;
    localparam int LIM_W = TIME_BITS + ppr_pkg::SPEED_W;
    localparam int CMP_W = (NUM_W > LIM_W) ? NUM_W : LIM_W;
    localparam int IV_W  = (TIME_BITS > ppr_pkg::MIN_W) ? TIME_BITS : ppr_pkg::MIN_W;
    localparam int TW    = (COUNT_BITS > ppr_pkg::TOTAL_W) ? COUNT_BITS : ppr_pkg::TOTAL_W;

    logic [ppr_pkg::CAL_W-1:0]   cal_reg;
    logic [ppr_pkg::MIN_W-1:0]   min_reg;
    logic [COUNT_BITS-1:0]       counter_reg;
    logic [TIME_BITS-1:0]        stamp_reg;
    logic [TIME_BITS-1:0]        elapsed_reg;
    logic [COUNT_BITS-1:0]       count_cap_reg;
    logic [NUM_W-1:0]            prod_reg;
    logic                        ovf_reg;
    logic                        ok_reg;
    logic [TIME_BITS-1:0]        rem_reg;
    logic [ppr_pkg::SPEED_W-1:0] low_reg;
    logic [ppr_pkg::SPEED_W-1:0] quo_reg;
    logic                        out_valid_reg;
    logic [ppr_pkg::SPEED_W-1:0] speed_reg;
    logic                        valid_res_reg;
    logic [ppr_pkg::TOTAL_W-1:0] total_reg;

    logic [TIME_BITS-1:0]        now_trim;
    logic [MUL_W-1:0]            mul_full;
    logic [CMP_W-1:0]            num_ext;
    logic [CMP_W-1:0]            lim_ext;
    logic                        ovf_next;
    logic                        ok_next;
    logic [TIME_BITS:0]          trial;
    logic [TIME_BITS:0]          divisor_ext;
    logic                        q_bit;
    logic [TIME_BITS:0]          diff;
    logic [ppr_pkg::TOTAL_W-1:0] total_next;
    logic [ppr_pkg::SPEED_W-1:0] speed_next;

    assign now_trim    = TIME_BITS'(now_time);
    assign mul_full    = count_cap_reg * cal_reg;
    assign num_ext     = CMP_W'(prod_reg);
    assign lim_ext     = CMP_W'(elapsed_reg) << ppr_pkg::SPEED_W;
    assign ovf_next    = (num_ext >= lim_ext);
    assign ok_next     = (elapsed_reg != '0) && (IV_W'(elapsed_reg) >= IV_W'(min_reg));
    assign trial       = {rem_reg, low_reg[ppr_pkg::SPEED_W-1]};
    assign divisor_ext = {1'b0, elapsed_reg};
    assign q_bit       = (trial >= divisor_ext);
    assign diff        = trial - divisor_ext;
    assign total_next  = (TW'(count_cap_reg) > TW'(ppr_pkg::TOTAL_MAX)) ?
                         ppr_pkg::TOTAL_MAX : ppr_pkg::TOTAL_W'(count_cap_reg);
    assign speed_next  = !ok_reg ? '0 : (ovf_reg ? ppr_pkg::SPEED_MAX : quo_reg);

    // Configuration and interval state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg     <= ppr_pkg::CAL_RESET;
            min_reg     <= ppr_pkg::MIN_RESET;
            counter_reg <= '0;
            stamp_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == ppr_pkg::CFG_CALIBRATION)
                begin
                    cal_reg <= wr_data[ppr_pkg::CAL_W-1:0];
                end
                else
                begin
                    min_reg <= wr_data[ppr_pkg::MIN_W-1:0];
                end
            end
            if (cmd.restart || cmd.capture)
            begin
                counter_reg <= '0;
                stamp_reg   <= now_trim;
            end
            else if (cmd.pulse && (counter_reg != {COUNT_BITS{1'b1}}))
            begin
                counter_reg <= counter_reg + 1'b1;
            end
        end
    end

    // Arithmetic: capture, multiply, range check, one quotient bit per step.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            elapsed_reg   <= now_trim - stamp_reg;
            count_cap_reg <= counter_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= {mul_full, {ppr_pkg::SCALE_SHIFT{1'b0}}};
        end
        if (cmd.check)
        begin
            ovf_reg <= ovf_next;
            ok_reg  <= ok_next;
            rem_reg <= TIME_BITS'(prod_reg[NUM_W-1:ppr_pkg::SPEED_W]);
            low_reg <= prod_reg[ppr_pkg::SPEED_W-1:0];
            quo_reg <= '0;
        end
        if (cmd.step)
        begin
            rem_reg <= q_bit ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            low_reg <= {low_reg[ppr_pkg::SPEED_W-2:0], 1'b0};
            quo_reg <= {quo_reg[ppr_pkg::SPEED_W-2:0], q_bit};
        end
        if (cmd.load_out)
        begin
            speed_reg     <= speed_next;
            valid_res_reg <= ok_reg;
            total_reg     <= total_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign speed_q8      = speed_reg;
    assign valid_res     = valid_res_reg;
    assign pulse_total   = total_reg;

endmodule

// ===== sv/propeller_pulse_rate_meter.sv =====
// Top level of the propeller pulse rate meter.
//
//   Channel   Direction  Carries                                  Handshake
//   sample    in         func, now_time                           valid/ready
//   result    out        speed_q8, valid_res, pulse_total         valid/ready
//   wr_*      in         wr_index, wr_data (calibration, minimum) wr_en only
//
// A pulse, restart or unused request is handled while idle, and the next request can
// follow at once. A read steps through capture, a multiply, a range check, a restoring
// divider at one quotient bit per cycle, and a load once the result register is free.
// Reset clears the pulse count and the stamp and restores the default configuration.
// A new request is taken while an earlier result waits in the result register;
// a read finishes only once that result has been taken.
module propeller_pulse_rate_meter #(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ppr_in_if.sink                           sample,
    ppr_out_if.source                        result,
    input  logic                             wr_en,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]   wr_data
);

    ppr_pkg::ppr_cmd_t           cmd;
    ppr_pkg::ppr_stat_t          stat;
    logic                        in_ready;
    logic                        out_valid;
    logic [ppr_pkg::SPEED_W-1:0] speed_q8;
    logic                        valid_res;
    logic [ppr_pkg::TOTAL_W-1:0] pulse_total;

    // The controller decodes each request and steps the datapath through a read.
    ppr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_func  (sample.func),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the count, the stamp, the configuration and the
    // multiply-then-divide arithmetic of a reading.
    ppr_dp #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .now_time    (sample.now_time),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .out_ready   (result.ready),
        .out_valid   (out_valid),
        .speed_q8    (speed_q8),
        .valid_res   (valid_res),
        .pulse_total (pulse_total)
    );

    assign sample.ready       = in_ready;
    assign result.valid       = out_valid;
    assign result.speed_q8    = speed_q8;
    assign result.valid_res   = valid_res;
    assign result.pulse_total = pulse_total;

endmodule

// ===== sv/ppr_checker.sv =====
// Port-level checker of the propeller pulse rate meter and its bind statement.
module ppr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [ppr_pkg::FUNC_W-1:0]      s_func,
    input logic                            r_valid,
    input logic                            r_ready,
    input logic [ppr_pkg::SPEED_W-1:0]     r_speed,
    input logic                            r_valid_res
);

    // A result that is not taken stays offered with the same speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_speed))
        else $error("result dropped or changed while stalled");

    // A read keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready && (s_func == ppr_pkg::FN_READ) |=> !s_ready)
        else $error("request taken during a read");

    // A pulse leaves the block ready again in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready && (s_func == ppr_pkg::FN_PULSE) |=> s_ready)
        else $error("pulse did not complete in one cycle");

    // An invalid reading reports zero speed.
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_valid_res |-> (r_speed == '0))
        else $error("nonzero speed on an invalid reading");

endmodule

bind propeller_pulse_rate_meter ppr_checker u_ppr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (sample.valid),
    .s_ready     (sample.ready),
    .s_func      (sample.func),
    .r_valid     (result.valid),
    .r_ready     (result.ready),
    .r_speed     (result.speed_q8),
    .r_valid_res (result.valid_res)
);
